// ===== src/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the temperature sample converter.
// ----------------------------------------------------------------------------
package stc_pkg;

  // sensor_kind codes
  localparam logic KIND_HUMIDITY = 1'b0;
  localparam logic KIND_PRESSURE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_KIND     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_SCALE       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_OFFSET      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_NUMERATOR   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_DENOMINATOR = 3'd4;

  localparam int unsigned CFG_DATA_W = 16;

  // humidity-sensor formula
  localparam logic [14:0]        HUM_GAIN = 15'd17572;
  localparam logic signed [15:0] HUM_BIAS = -16'sd4685;

  // divider geometry: dividend magnitude up to 2^26, divisor up to 2^18
  localparam int unsigned NUM_W     = 27;
  localparam int unsigned DEN_W     = 19;
  localparam int unsigned DIV_STEPS = NUM_W;

  // stage map: diff, product, divider setup, one stage per quotient bit,
  // post-processing, output register
  localparam int unsigned NUM_STAGES = DIV_STEPS + 5;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] hum;
    logic signed [17:0] x1;
    logic               zero;
    logic               qneg;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [NUM_W-1:0] nmag;
    logic [DEN_W-1:0] dmag;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] q;
  } div_t;

endpackage

// ===== src/sensor_temperature_conversion.sv =====
// ----------------------------------------------------------------------------
// sensor_temperature_conversion
// Converts a raw 16-bit temperature sample to hundredths of a degree Celsius.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_stall is low; the 27-stage restoring
// divider takes one quotient bit per stage, so a new item enters every cycle.
// Stalls collapse bubbles stage by stage; no item is lost or repeated.
// Reset (rst, synchronous): clears all stage valid bits and sets every
// configuration register to 0.
module sensor_temperature_conversion (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [stc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [15:0]                           raw_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [15:0]                    temp_centi,
  output logic                                  div_fault
);

  localparam int unsigned LAST     = stc_pkg::NUM_STAGES - 1;
  localparam int unsigned ST_DIV0  = 2;
  localparam int unsigned ST_POST  = ST_DIV0 + stc_pkg::DIV_STEPS + 1;

  // configuration registers
  logic               sensor_kind;
  logic signed [15:0] cal_scale;
  logic signed [15:0] cal_offset;
  logic signed [15:0] cal_numerator;
  logic signed [15:0] cal_denominator;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_kind     <= stc_pkg::KIND_HUMIDITY;
      cal_scale       <= '0;
      cal_offset      <= '0;
      cal_numerator   <= '0;
      cal_denominator <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        stc_pkg::REG_SENSOR_KIND:     sensor_kind     <= cfg_data[0];
        stc_pkg::REG_CAL_SCALE:       cal_scale       <= $signed(cfg_data);
        stc_pkg::REG_CAL_OFFSET:      cal_offset      <= $signed(cfg_data);
        stc_pkg::REG_CAL_NUMERATOR:   cal_numerator   <= $signed(cfg_data);
        stc_pkg::REG_CAL_DENOMINATOR: cal_denominator <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // stage valid bits and the ready chain
  logic [LAST:0] v;
  logic [LAST:0] rdy;

  always_comb begin
    rdy[LAST] = !v[LAST] || !out_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i <= LAST; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v[LAST];

  // stage 0: offset difference and humidity formula
  logic [15:0]        raw_masked;
  logic [30:0]        hum_prod;
  logic signed [15:0] hum_s0;
  logic signed [17:0] diff_s0;

  assign raw_masked = {raw_sample[15:2], 2'b00};
  assign hum_prod   = raw_masked * stc_pkg::HUM_GAIN;
  assign hum_s0     = $signed({1'b0, hum_prod[30:16]}) + stc_pkg::HUM_BIAS;
  assign diff_s0    = $signed({2'b00, raw_sample}) - {{2{cal_offset[15]}}, cal_offset};

  logic               kind_r0;
  logic signed [15:0] hum_r0;
  logic signed [17:0] diff_r0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      kind_r0 <= sensor_kind;
      hum_r0  <= hum_s0;
      diff_r0 <= diff_s0;
    end
  end

  // stage 1: scale product
  logic               kind_r1;
  logic signed [15:0] hum_r1;
  logic signed [33:0] prod_r1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      kind_r1 <= kind_r0;
      hum_r1  <= hum_r0;
      prod_r1 <= diff_r0 * cal_scale;
    end
  end

  // stage 2: x1, divisor, signs and magnitudes
  logic signed [17:0]                 x1_s2;
  logic signed [stc_pkg::DEN_W-1:0]   dvs_s2;
  logic signed [stc_pkg::NUM_W-1:0]   num_s2;
  logic [stc_pkg::NUM_W-1:0]          nmag_s2;
  logic [stc_pkg::DEN_W-1:0]          dmag_s2;

  // product fits in 33 bits, so floor(prod / 2^15) fits in 18
  assign x1_s2   = prod_r1[32:15];
  assign dvs_s2  = {x1_s2[17], x1_s2} + {{3{cal_denominator[15]}}, cal_denominator};
  assign num_s2  = {cal_numerator, 11'b0};
  assign nmag_s2 = num_s2[stc_pkg::NUM_W-1] ? stc_pkg::NUM_W'(-num_s2)
                                            : stc_pkg::NUM_W'(num_s2);
  assign dmag_s2 = dvs_s2[stc_pkg::DEN_W-1] ? stc_pkg::DEN_W'(-dvs_s2)
                                            : stc_pkg::DEN_W'(dvs_s2);

  stc_pkg::div_t dv [0:stc_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rdy[ST_DIV0]) begin
      dv[0].side.kind <= kind_r1;
      dv[0].side.hum  <= hum_r1;
      dv[0].side.x1   <= x1_s2;
      dv[0].side.zero <= (dvs_s2 == '0);
      dv[0].side.qneg <= num_s2[stc_pkg::NUM_W-1] ^ dvs_s2[stc_pkg::DEN_W-1];
      dv[0].nmag      <= nmag_s2;
      dv[0].dmag      <= dmag_s2;
      dv[0].rem       <= '0;
      dv[0].q         <= '0;
    end
  end

  // restoring divider: one quotient bit per stage, most significant first
  for (genvar k = 0; k < stc_pkg::DIV_STEPS; k++) begin : g_div
    localparam int unsigned BIT = stc_pkg::DIV_STEPS - 1 - k;

    logic [stc_pkg::DEN_W:0]   trial;
    logic [stc_pkg::DEN_W:0]   diff;
    logic                      qbit;
    stc_pkg::div_t             nxt;

    always_comb begin
      trial = {dv[k].rem, dv[k].nmag[BIT]};
      diff  = trial - {1'b0, dv[k].dmag};
      qbit  = (trial >= {1'b0, dv[k].dmag});
      nxt      = dv[k];
      nxt.rem  = qbit ? diff[stc_pkg::DEN_W-1:0] : trial[stc_pkg::DEN_W-1:0];
      nxt.q    = {dv[k].q[stc_pkg::NUM_W-2:0], qbit};
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_DIV0 + 1 + k]) dv[k+1] <= nxt;
    end
  end

  // post stage: sign the quotient, b5 and the rounding shift
  stc_pkg::div_t        dq;
  logic signed [27:0]   qs;
  logic signed [28:0]   b5;
  logic signed [28:0]   b5r;

  assign dq  = dv[stc_pkg::DIV_STEPS];
  assign qs  = dq.side.qneg ? -$signed({1'b0, dq.q}) : $signed({1'b0, dq.q});
  assign b5  = {{11{dq.side.x1[17]}}, dq.side.x1} + {qs[27], qs};
  assign b5r = (b5 + 29'sd8) >>> 4;

  logic               kind_rp;
  logic signed [15:0] hum_rp;
  logic               zero_rp;
  logic signed [24:0] t_rp;

  always_ff @(posedge clk) begin
    if (rdy[ST_POST]) begin
      kind_rp <= dq.side.kind;
      hum_rp  <= dq.side.hum;
      zero_rp <= dq.side.zero;
      t_rp    <= b5r[24:0];
    end
  end

  // output stage: times ten, saturate, select formula
  logic signed [28:0] t10;
  logic signed [15:0] sat;
  logic signed [15:0] temp_next;
  logic               fault_next;

  assign t10 = ({{4{t_rp[24]}}, t_rp} <<< 3) + ({{4{t_rp[24]}}, t_rp} <<< 1);

  always_comb begin
    if (t10 > 29'sd32767) begin
      sat = 16'sh7FFF;
    end else if (t10 < -29'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = t10[15:0];
    end
    if (kind_rp == stc_pkg::KIND_HUMIDITY) begin
      temp_next  = hum_rp;
      fault_next = 1'b0;
    end else if (zero_rp) begin
      temp_next  = '0;
      fault_next = 1'b1;
    end else begin
      temp_next  = sat;
      fault_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      temp_centi <= temp_next;
      div_fault  <= fault_next;
    end
  end

endmodule

// ===== test/tb_sensor_temperature_conversion.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_temperature_conversion
// Self-checking bench for the temperature sample converter. A scoreboard
// predicts hundredths of a degree for every accepted sample under the current
// calibration and compares each result in order. Directed items cover both
// formulas, cleared status bits, a zero divisor, saturation at both bounds and
// writes to unused register slots. Random phases follow, with random
// calibration, random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sensor_temperature_conversion;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int SETTLE_CYCLES   = 40;
  localparam int LONG_HOLD       = 150;

  localparam logic [15:0] STATUS_MASK = 16'hFFFC;
  localparam longint HUMID_GAIN = 17572;
  localparam longint HUMID_BIAS = -4685;

  typedef struct {
    logic signed [15:0] temp;
    logic               fault;
  } temp_result_t;

  class temp_scoreboard;
    logic               kind;
    logic signed [15:0] scale;
    logic signed [15:0] offset;
    logic signed [15:0] numer;
    logic signed [15:0] denom;
    temp_result_t       expected_temps[$];
    int                 errors;

    function new();
      kind   = stc_pkg::KIND_HUMIDITY;
      scale  = '0;
      offset = '0;
      numer  = '0;
      denom  = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [stc_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] d);
      unique case (idx)
        stc_pkg::REG_SENSOR_KIND:     kind   = d[0];
        stc_pkg::REG_CAL_SCALE:       scale  = d;
        stc_pkg::REG_CAL_OFFSET:      offset = d;
        stc_pkg::REG_CAL_NUMERATOR:   numer  = d;
        stc_pkg::REG_CAL_DENOMINATOR: denom  = d;
        default: ;
      endcase
    endfunction

    function temp_result_t convert_sample(logic [15:0] raw);
      temp_result_t r;
      longint       val;
      longint       x1;
      longint       divisor;
      longint       x2;
      longint       b5;
      r.fault = 1'b0;
      if (kind == stc_pkg::KIND_HUMIDITY) begin
        val = HUMID_BIAS + ((longint'(raw & STATUS_MASK) * HUMID_GAIN) >>> 16);
      end else begin
        // arithmetic shift floors, division truncates toward zero
        x1 = ((longint'(raw) - longint'(offset)) * longint'(scale)) >>> 15;
        divisor = x1 + longint'(denom);
        if (divisor == 0) begin
          val = 0;
          r.fault = 1'b1;
        end else begin
          x2 = (longint'(numer) * 2048) / divisor;
          b5 = x1 + x2;
          val = ((b5 + 8) >>> 4) * 10;
        end
      end
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      r.temp = val[15:0];
      return r;
    endfunction

    function void note_sample(logic [15:0] raw);
      expected_temps.push_back(convert_sample(raw));
    endfunction

    function void check_result(logic signed [15:0] temp, logic fault);
      temp_result_t want;
      if (expected_temps.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: temp %0d fault %b",
                 $time, temp, fault);
        return;
      end
      want = expected_temps.pop_front();
      if (temp !== want.temp) begin
        errors++;
        $display("%0t: temp_centi expected %0d actual %0d", $time, want.temp, temp);
      end
      if (fault !== want.fault) begin
        errors++;
        $display("%0t: div_fault expected %b actual %b", $time, want.fault, fault);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst        = 1'b1;
  logic                            cfg_write  = 1'b0;
  logic [stc_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                            in_valid   = 1'b0;
  logic                            in_stall;
  logic [15:0]                     raw_sample = '0;
  logic                            out_valid;
  logic                            out_stall  = 1'b0;
  logic signed [15:0]              temp_centi;
  logic                            div_fault;

  temp_scoreboard sb = new();
  int  cycle_count   = 0;
  int  stall_left    = 0;
  int  hold_left     = 0;
  bit  no_idle       = 1'b0;
  bit  long_hold_req = 1'b0;

  sensor_temperature_conversion i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_sample (raw_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .temp_centi (temp_centi),
    .div_fault  (div_fault)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sensor_temperature_conversion: FAIL");
      $finish;
    end
  end

  // result side: check accepted items, then draw the next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(temp_centi, div_fault);
        stall_left = no_idle ? 0 : int'($urandom_range(0, 3));
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  task automatic send_sample(input logic [15:0] v);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_sample <= v;
    do @(posedge clk); while (in_stall);
    sb.note_sample(v);
  endtask

  // leaves cfg_write high; the caller drops it after the last write
  task automatic write_reg(input logic [stc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic program_regs(input logic kind, input logic [15:0] scale,
                              input logic [15:0] offset, input logic [15:0] numer,
                              input logic [15:0] denom);
    logic [14:0] junk;
    junk = 15'($urandom);
    write_reg(stc_pkg::REG_SENSOR_KIND, {junk, kind});
    write_reg(stc_pkg::REG_CAL_SCALE, scale);
    write_reg(stc_pkg::REG_CAL_OFFSET, offset);
    write_reg(stc_pkg::REG_CAL_NUMERATOR, numer);
    write_reg(stc_pkg::REG_CAL_DENOMINATOR, denom);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_temps.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_cal();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'hFFFF;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'h7FFF;
        endcase
      end
      1: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // bias some samples toward the offset so x1 stays small
  function automatic logic [15:0] pick_raw(input logic [15:0] pivot);
    if ($urandom_range(0, 4) == 0)
      return pivot + 16'($urandom_range(0, 15)) - 16'd8;
    return 16'($urandom);
  endfunction

  initial begin
    logic [15:0] rand_offset;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // humidity formula at reset calibration, status bits cleared
    send_sample(16'h0000);
    send_sample(16'h0003);
    send_sample(16'h0004);
    send_sample(16'hFFFF);
    send_sample(16'hFFFC);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    drain();

    // pressure formula with zeroed calibration: divisor is always zero
    program_regs(stc_pkg::KIND_PRESSURE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    drain();

    // x1 = -raw, divisor crosses zero around raw 100: saturate high, fault, saturate low
    program_regs(stc_pkg::KIND_PRESSURE, 16'h8000, 16'h0000, 16'h7FFF, 16'd100);
    send_sample(16'd98);
    send_sample(16'd99);
    send_sample(16'd100);
    send_sample(16'd101);
    send_sample(16'd102);
    drain();

    program_regs(stc_pkg::KIND_PRESSURE, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    drain();

    // typical calibration; unused slots must not touch it
    program_regs(stc_pkg::KIND_PRESSURE, 16'd32757, 16'd23153, -16'sd8711, 16'd2868);
    for (int i = int'(stc_pkg::REG_CAL_DENOMINATOR) + 1; i < 2 ** stc_pkg::CFG_INDEX_W;
         i++)
      write_reg(i[stc_pkg::CFG_INDEX_W-1:0], 16'hFFFF);
    cfg_write <= 1'b0;
    send_sample(16'd27898);
    send_sample(16'd23153);
    send_sample(16'd0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      no_idle = (ph % 4 == 1);
      rand_offset = pick_cal();
      program_regs(1'($urandom_range(0, 1)), pick_cal(), rand_offset, pick_cal(),
                   pick_cal());
      // hold the output so the pipeline fills and backs up the input
      if (ph == 2) long_hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_sample(pick_raw(rand_offset));
      drain();
    end

    no_idle = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_temps.size() == 0)
      $display("tb_sensor_temperature_conversion: PASS");
    else
      $display("tb_sensor_temperature_conversion: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/stc_pkg.sv
src/sensor_temperature_conversion.sv
test/tb_sensor_temperature_conversion.sv
